@@ rtl/cpiq_pkg.sv @@
// cpiq_pkg: request/result payload types, ring entry type, sizes and codes
// shared by the controller, the datapath and the top level
package cpiq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IMAGE_BYTES = 4096;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ENQ   = 2'd1;
    localparam logic [1:0] REQ_DISC  = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_MON   = 2'd2;
    localparam logic [1:0] CMD_OTHER = 2'd3;

    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  command;
        logic [3:0]  client;
        logic [7:0]  channel;
        logic [11:0] offset;
        logic [5:0]  access_bits;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  reply_client;
        logic [1:0]  reply_command;
        logic [7:0]  reply_channel;
        logic [31:0] reply_value;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  client;
        logic [7:0]  channel;
        logic [11:0] offset;
        logic [5:0]  access_bits;
        logic [31:0] value;
    } t_entry;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;     // latch the accepted request
        logic push_req;    // push request entry at tail
        logic load_byte;   // write request byte into image
        logic rd_head;     // read ring at head
        logic pop_latch;   // latch ring read data as work entry
        logic push_work;   // push work entry at tail
        logic pop;         // advance head
        logic img_rd;      // read image byte at work offset + idx
        logic img_wr;      // write work byte at work offset + idx
        logic img_cap;     // merge image read data into work value
        logic idx_clr;
        logic idx_inc;
        logic out_load;    // load output register
        logic [1:0] out_sel; // KIND_* of the result
        logic out_last;
        logic cnt_load;    // latch ring count as remaining
        logic cnt_dec;
    } t_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic       full;
        logic       rem_zero;  // remaining is zero
        logic       rem_one;
        logic [1:0] req_type;
        logic [1:0] w_command;
        logic       w_match;   // work entry client equals disconnect client
        logic [2:0] w_bytes;   // bytes to touch for the work entry
        logic [1:0] idx;
    } t_sts;

endpackage

@@ rtl/cpiq_datapath.sv @@
// cpiq_datapath: command ring memory, process image memory, work entry
// and output register; depends on cpiq_pkg
module cpiq_datapath
    import cpiq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_req,
    input  t_ctl i_ctl,
    input  logic [$clog2(IMAGE_BYTES)-1:0] i_clr_addr,
    input  logic i_clr_we,
    output t_sts o_sts,
    output t_out o_out
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(IMAGE_BYTES);

    t_entry ring_mem [QUEUE_DEPTH];
    logic [7:0] img_mem [IMAGE_BYTES];

    logic [QW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count, r_rem;
    t_in    r_req;
    t_entry r_work, r_rdata;
    logic [7:0] r_img_q;
    logic [1:0] r_idx;
    t_out   r_out;

    logic [AW-1:0] w_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic          push;
    t_entry        push_data;

    function automatic logic [QW-1:0] ring_inc(input logic [QW-1:0] p);
        if ({{(32-QW){1'b0}}, p} == QUEUE_DEPTH - 1) begin
            ring_inc = '0;
        end else begin
            ring_inc = p + 1'b1;
        end
    endfunction

    // offset plus byte index, wrapped to the image size
    assign w_addr = AW'(({20'd0, r_work.offset} + {30'd0, r_idx}) % IMAGE_BYTES);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_clr_addr;
        wr_data = '0;
        if (i_clr_we) begin
            wr_en = 1'b1;
        end else if (i_ctl.load_byte) begin
            wr_en   = 1'b1;
            wr_addr = AW'({20'd0, r_req.offset} % IMAGE_BYTES);
            wr_data = r_req.value[7:0];
        end else if (i_ctl.img_wr) begin
            wr_en   = 1'b1;
            wr_addr = w_addr;
            wr_data = r_work.value[8*r_idx +: 8];
        end
    end

    assign push = i_ctl.push_req | i_ctl.push_work;
    assign push_data = i_ctl.push_req ?
        {r_req.command, r_req.client, r_req.channel, r_req.offset,
         r_req.access_bits, r_req.value} : r_work;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            img_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.img_rd) begin
            r_img_q <= img_mem[w_addr];
        end
        if (push) begin
            ring_mem[r_tail] <= push_data;
        end
        if (i_ctl.rd_head) begin
            r_rdata <= ring_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rem   <= '0;
            r_idx   <= '0;
        end else begin
            if (push) begin
                r_tail <= ring_inc(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= ring_inc(r_head);
            end
            if (push && !i_ctl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_ctl.pop) begin
                r_count <= r_count - 1'b1;
            end
            if (i_ctl.cnt_load) begin
                r_rem <= r_count;
            end else if (i_ctl.cnt_dec) begin
                r_rem <= r_rem - 1'b1;
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_req <= i_req;
        end
        if (i_ctl.pop_latch) begin
            // reads of a valid width start from zero
            if ((r_rdata.command == CMD_READ || r_rdata.command == CMD_MON) &&
                (r_rdata.access_bits == 6'd8 || r_rdata.access_bits == 6'd16 ||
                 r_rdata.access_bits == 6'd32)) begin
                r_work <= {r_rdata.command, r_rdata.client, r_rdata.channel,
                           r_rdata.offset, r_rdata.access_bits, 32'd0};
            end else begin
                r_work <= r_rdata;
            end
        end else if (i_ctl.img_cap) begin
            r_work.value[8*r_idx +: 8] <= r_img_q;
        end
        if (i_ctl.out_load) begin
            case (i_ctl.out_sel)
                KIND_REPLY: begin
                    r_out <= {KIND_REPLY, r_work.client, r_work.command,
                              r_work.channel, r_work.value, i_ctl.out_last};
                end
                KIND_RELEASE: begin
                    r_out <= {KIND_RELEASE, r_req.client, 2'd0, 8'd0, 32'd0,
                              i_ctl.out_last};
                end
                default: begin
                    r_out <= {KIND_REJECT, r_req.client, r_req.command,
                              r_req.channel, r_req.value, i_ctl.out_last};
                end
            endcase
        end
    end

    always_comb begin
        o_sts.full      = (r_count == CW'(QUEUE_DEPTH));
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.rem_one   = (r_rem == CW'(1));
        o_sts.req_type  = r_req.req_type;
        o_sts.w_command = r_work.command;
        o_sts.w_match   = (r_work.client == r_req.client);
        o_sts.idx       = r_idx;
        case (r_work.access_bits)
            6'd1, 6'd8: o_sts.w_bytes = (r_work.command == CMD_WRITE) ||
                                         (r_work.access_bits == 6'd8) ? 3'd1 : 3'd0;
            6'd16:      o_sts.w_bytes = 3'd2;
            6'd32:      o_sts.w_bytes = 3'd4;
            default:    o_sts.w_bytes = 3'd0;
        endcase
    end

    assign o_out = r_out;

endmodule

@@ rtl/cpiq_ctrl.sv @@
// cpiq_ctrl: sequencer for enqueue, load, disconnect purge and tick walk,
// plus the image clearing pass after reset; depends on cpiq_pkg
module cpiq_ctrl
    import cpiq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic [$clog2(IMAGE_BYTES)-1:0] o_clr_addr,
    output logic o_clr_we
);
    localparam int AW = $clog2(IMAGE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RD, S_LATCH, S_BYTE_RD, S_BYTE_CAP,
        S_BYTE_WR, S_EMIT, S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic r_valid, n_valid;
    logic r_disc, n_disc;    // walking for a disconnect
    logic r_last, n_last;
    // disconnect on an empty ring has no work entry to keep
    logic r_nowork, n_nowork;
    logic out_full;

    assign out_full = r_valid && !i_ready;
    assign o_ready  = (r_state == S_IDLE) && !out_full;
    assign o_valid  = r_valid;
    assign o_clr_addr = r_clr;
    assign o_clr_we   = (r_state == S_CLEAR);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_disc  = r_disc;
        n_last  = r_last;
        n_valid = r_valid && !i_ready;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if ({{(32-AW){1'b0}}, r_clr} == IMAGE_BYTES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_ctl.capture  = 1'b1;
                    o_ctl.cnt_load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.req_type)
                    REQ_ENQ: begin
                        if (i_sts.full) begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_sel  = KIND_REJECT;
                            o_ctl.out_last = 1'b1;
                            n_valid = 1'b1;
                        end else begin
                            o_ctl.push_req = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    REQ_LOAD: begin
                        o_ctl.load_byte = 1'b1;
                        n_state = S_IDLE;
                    end
                    REQ_DISC: begin
                        n_disc = 1'b1;
                        n_state = i_sts.rem_zero ? S_EMIT : S_RD;
                    end
                    default: begin
                        n_disc = 1'b0;
                        n_state = i_sts.rem_zero ? S_IDLE : S_RD;
                    end
                endcase
            end
            S_RD: begin
                o_ctl.rd_head = 1'b1;
                n_state = S_LATCH;
            end
            S_LATCH: begin
                o_ctl.pop_latch = 1'b1;
                o_ctl.pop       = 1'b1;
                o_ctl.idx_clr   = 1'b1;
                n_last = i_sts.rem_one;
                o_ctl.cnt_dec   = 1'b1;
                n_state = r_disc ? S_EMIT : S_BYTE_RD;
            end
            S_BYTE_RD: begin
                if ({1'b0, i_sts.idx} >= i_sts.w_bytes ||
                    i_sts.w_command == CMD_OTHER) begin
                    n_state = S_EMIT;
                end else if (i_sts.w_command == CMD_WRITE) begin
                    n_state = S_BYTE_WR;
                end else begin
                    o_ctl.img_rd = 1'b1;
                    n_state = S_BYTE_CAP;
                end
            end
            S_BYTE_CAP: begin
                o_ctl.img_cap = 1'b1;
                o_ctl.idx_inc = 1'b1;
                n_state = ({1'b0, i_sts.idx} + 3'd1 >= i_sts.w_bytes) ?
                          S_EMIT : S_BYTE_RD;
            end
            S_BYTE_WR: begin
                o_ctl.img_wr  = 1'b1;
                o_ctl.idx_inc = 1'b1;
                n_state = ({1'b0, i_sts.idx} + 3'd1 >= i_sts.w_bytes) ?
                          S_EMIT : S_BYTE_WR;
            end
            S_EMIT: begin
                if (r_disc && !i_sts.rem_zero && !r_last) begin
                    // purge step in the middle of the walk
                    o_ctl.push_work = !i_sts.w_match;
                    n_state = S_RD;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!out_full) begin
                    if (r_disc) begin
                        if (!r_nowork) begin
                            o_ctl.push_work = !i_sts.w_match;
                        end
                        o_ctl.out_load = 1'b1;
                        o_ctl.out_sel  = KIND_RELEASE;
                        o_ctl.out_last = 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.push_work = (i_sts.w_command == CMD_MON);
                        o_ctl.out_load = 1'b1;
                        o_ctl.out_sel  = KIND_REPLY;
                        o_ctl.out_last = r_last;
                        n_valid = 1'b1;
                        n_state = r_last ? S_IDLE : S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_nowork = r_nowork;
        if (r_state == S_DECODE) begin
            n_nowork = i_sts.rem_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_valid  <= 1'b0;
            r_disc   <= 1'b0;
            r_last   <= 1'b0;
            r_nowork <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_valid  <= n_valid;
            r_disc   <= n_disc;
            r_last   <= n_last;
            r_nowork <= n_nowork;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request accepted during image clear");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_full |=> r_valid)
        else $error("result dropped while stalled");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.out_load && r_state != S_DECODE) |-> !out_full)
        else $error("output register overwritten");
`endif

endmodule

@@ rtl/cyclic_process_image_command_queue_core.sv @@
// channel | handshake            | payload
// request | i_valid / o_ready    | i_req  (t_in)
// result  | o_valid / i_ready    | o_res  (t_out)
// enqueue and load pass from S_DECODE back to S_IDLE; a tick walks each entry
// through S_RD, S_LATCH and S_BYTE_RD, then S_BYTE_CAP per byte for a read or
// monitor or S_BYTE_WR per byte for a write, then S_EMIT and S_WAIT; a disconnect
// walks each entry through S_RD, S_LATCH and S_EMIT, ends in S_WAIT and goes from
// S_DECODE to S_EMIT on an empty ring. after reset a clearing pass zeroes every
// image byte with o_ready low; a stalled result holds the walk and next request.
// top level: joins cpiq_ctrl and cpiq_datapath; depends on cpiq_pkg
module cyclic_process_image_command_queue_core
    import cpiq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_res
);
    t_ctl ctl;
    t_sts sts;
    logic [$clog2(IMAGE_BYTES)-1:0] clr_addr;
    logic clr_we;

    cpiq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(sts), .o_ctl(ctl),
        .o_clr_addr(clr_addr), .o_clr_we(clr_we)
    );

    cpiq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_ctl(ctl),
        .i_clr_addr(clr_addr), .i_clr_we(clr_we), .o_sts(sts), .o_out(o_res)
    );

endmodule
